>>> design/mt64_pkg.sv
// ----------------------------------------------------------------------------
// mt64_pkg
// Shared types and constants for the 64-bit Mersenne Twister generator.
// ----------------------------------------------------------------------------
package mt64_pkg;

  // state pool geometry
  localparam int STATE_DEPTH   = 312;
  localparam int MIDDLE_OFFSET = 156;
  localparam int WORD_W        = 64;
  localparam int ADDR_W        = $clog2(STATE_DEPTH);
  localparam int FRAC_W        = 53;

  // index value that marks a pool that was never seeded
  localparam logic [ADDR_W-1:0] IDX_UNSEEDED = ADDR_W'(STATE_DEPTH + 1);
  localparam logic [ADDR_W-1:0] IDX_SPENT    = ADDR_W'(STATE_DEPTH);
  localparam logic [ADDR_W-1:0] IDX_LAST     = ADDR_W'(STATE_DEPTH - 1);
  localparam logic [ADDR_W-1:0] IDX_MIDDLE   = ADDR_W'(MIDDLE_OFFSET);

  // generator constants
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
  localparam logic [WORD_W-1:0] UPPER_MASK   = 64'hFFFF_FFFF_8000_0000;
  localparam logic [WORD_W-1:0] LOWER_MASK   = 64'h0000_0000_7FFF_FFFF;
  localparam logic [WORD_W-1:0] SEED_MULT    = 64'd6364136223846793005;
  localparam logic [WORD_W-1:0] SEED_RESET   = 64'd5489;
  localparam logic [WORD_W-1:0] TEMPER_B     = 64'h5555_5555_5555_5555;
  localparam logic [WORD_W-1:0] TEMPER_C     = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [WORD_W-1:0] TEMPER_D     = 64'hFFF7_EEE0_0000_0000;

  // multiply phases of one seeding step
  typedef enum logic [1:0] {
    PH_LO_LO = 2'd0,
    PH_LO_HI = 2'd1,
    PH_HI_LO = 2'd2,
    PH_SUM   = 2'd3
  } seed_phase_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED_FIRST,
    ST_SEED_MUL,
    ST_TW_PRE,
    ST_TW_FAR,
    ST_TW_NEXT,
    ST_TW_WRITE,
    ST_FETCH,
    ST_DRAW
  } mt_state_t;

endpackage

>>> design/mersenne_twister_64_generator.sv
// ----------------------------------------------------------------------------
// mersenne_twister_64_generator
// 64-bit Mersenne Twister (mt19937_64) with the state pool held in a RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / restart): each transfer requests one
//   draw; restart = 1 reseeds the pool from the seed register first.
//   Output channel (out_valid / out_stall / random_word / unit_fraction):
//   one transfer per request, in request order. unit_fraction is the
//   numerator over 2^53 of ((word >> 12) + 0.5) / 2^52.
//   Config channel (cfg_valid / cfg_ready / seed): writes the seed register,
//   always ready; a new seed takes effect at the next seeding (a restart, or the first draw after reset).
// Sequence:
//   A plain draw is accepted, reads the RAM, then tempers into the output
//   register. When the pool is spent, a twist pass over all 312 words runs
//   first: each word needs two reads on the single RAM read port plus a
//   write-back. Seeding (first draw after reset, or restart) comes before
//   the twist and uses one 32x32 multiplier over three phases per word.
// Reset clears control and loads the seed register with 5489; the pool is
// seeded on the first draw. A stalled result sits in the output register; a
// following request is taken but its result waits until the register frees.
// ----------------------------------------------------------------------------
module mersenne_twister_64_generator (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        restart,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] random_word,
  output logic [52:0] unit_fraction,
  // seed register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] seed
);

  localparam int AW = mt64_pkg::ADDR_W;
  localparam int WW = mt64_pkg::WORD_W;

  mt64_pkg::mt_state_t   state, state_next;
  mt64_pkg::seed_phase_t phase;

  logic [WW-1:0] seed_word;
  logic [AW-1:0] read_index;
  logic [AW-1:0] k;
  logic [WW-1:0] prev;
  logic [WW-1:0] prod;
  logic [WW-1:0] acc;
  logic [WW-1:0] cur;
  logic [WW-1:0] far_word;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  logic          in_xfer;
  logic          out_free;
  logic          need_seed;
  logic [WW-1:0] mix;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [WW-1:0] mul_p;
  logic [WW-1:0] seed_sum;
  logic [AW-1:0] far_addr;
  logic [AW-1:0] next_addr;
  logic [WW-1:0] twist_y;
  logic [WW-1:0] twist_v;
  logic [WW-1:0] tempered;

  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign need_seed = restart || (read_index > mt64_pkg::IDX_SPENT);

  // state pool
  mt64_ram #(
    .WIDTH (mt64_pkg::WORD_W),
    .DEPTH (mt64_pkg::STATE_DEPTH)
  ) u_pool (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // seeding recurrence: low 64 bits of mult * mix, built from 32-bit partials
  assign mix = prev ^ (prev >> 62);

  always_comb begin
    case (phase)
      mt64_pkg::PH_LO_LO: begin
        mul_a = mix[31:0];
        mul_b = mt64_pkg::SEED_MULT[31:0];
      end
      mt64_pkg::PH_LO_HI: begin
        mul_a = mix[31:0];
        mul_b = mt64_pkg::SEED_MULT[63:32];
      end
      default: begin
        mul_a = mix[63:32];
        mul_b = mt64_pkg::SEED_MULT[31:0];
      end
    endcase
  end

  assign mul_p    = {32'b0, mul_a} * {32'b0, mul_b};
  assign seed_sum = acc + {prod[31:0], 32'b0};

  // twist neighbors and update
  assign far_addr  = (k < mt64_pkg::IDX_MIDDLE) ? (k + mt64_pkg::IDX_MIDDLE)
                                                : (k - mt64_pkg::IDX_MIDDLE);
  assign next_addr = (k == mt64_pkg::IDX_LAST) ? '0 : (k + AW'(1));
  assign twist_y   = (cur & mt64_pkg::UPPER_MASK) | (ram_rdata & mt64_pkg::LOWER_MASK);
  assign twist_v   = far_word ^ (twist_y >> 1)
                   ^ (twist_y[0] ? mt64_pkg::TWIST_MATRIX : '0);

  // tempering
  always_comb begin
    logic [WW-1:0] t;
    t = ram_rdata;
    t = t ^ ((t >> 29) & mt64_pkg::TEMPER_B);
    t = t ^ ((t << 17) & mt64_pkg::TEMPER_C);
    t = t ^ ((t << 37) & mt64_pkg::TEMPER_D);
    t = t ^ (t >> 43);
    tempered = t;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      mt64_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (need_seed) begin
            state_next = mt64_pkg::ST_SEED_FIRST;
          end else if (read_index == mt64_pkg::IDX_SPENT) begin
            state_next = mt64_pkg::ST_TW_PRE;
          end else begin
            state_next = mt64_pkg::ST_FETCH;
          end
        end
      end
      mt64_pkg::ST_SEED_FIRST: state_next = mt64_pkg::ST_SEED_MUL;
      mt64_pkg::ST_SEED_MUL: begin
        if (phase == mt64_pkg::PH_SUM && k == mt64_pkg::IDX_LAST) begin
          state_next = mt64_pkg::ST_TW_PRE;
        end
      end
      mt64_pkg::ST_TW_PRE:  state_next = mt64_pkg::ST_TW_FAR;
      mt64_pkg::ST_TW_FAR:  state_next = mt64_pkg::ST_TW_NEXT;
      mt64_pkg::ST_TW_NEXT: state_next = mt64_pkg::ST_TW_WRITE;
      mt64_pkg::ST_TW_WRITE: begin
        state_next = (k == mt64_pkg::IDX_LAST) ? mt64_pkg::ST_FETCH
                                               : mt64_pkg::ST_TW_FAR;
      end
      mt64_pkg::ST_FETCH: state_next = mt64_pkg::ST_DRAW;
      mt64_pkg::ST_DRAW: begin
        if (out_free) begin
          state_next = mt64_pkg::ST_IDLE;
        end
      end
      default: state_next = mt64_pkg::ST_IDLE;
    endcase
  end

  // ram control and handshake outputs
  always_comb begin
    in_stall  = 1'b1;
    ram_we    = 1'b0;
    ram_waddr = k;
    ram_wdata = twist_v;
    ram_re    = 1'b0;
    ram_raddr = read_index;
    unique case (state)
      mt64_pkg::ST_IDLE: in_stall = 1'b0;
      mt64_pkg::ST_SEED_FIRST: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = seed_word;
      end
      mt64_pkg::ST_SEED_MUL: begin
        ram_we    = (phase == mt64_pkg::PH_SUM);
        ram_wdata = seed_sum;
      end
      mt64_pkg::ST_TW_PRE: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      mt64_pkg::ST_TW_FAR: begin
        ram_re    = 1'b1;
        ram_raddr = far_addr;
      end
      mt64_pkg::ST_TW_NEXT: begin
        ram_re    = 1'b1;
        ram_raddr = next_addr;
      end
      mt64_pkg::ST_TW_WRITE: ram_we = 1'b1;
      mt64_pkg::ST_FETCH:    ram_re = 1'b1;
      mt64_pkg::ST_DRAW:     ram_re = 1'b0;
      default:               in_stall = 1'b1;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mt64_pkg::ST_IDLE;
      seed_word  <= mt64_pkg::SEED_RESET;
      read_index <= mt64_pkg::IDX_UNSEEDED;
      phase      <= mt64_pkg::PH_LO_LO;
      k          <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      // seed register transfer
      if (cfg_valid && cfg_ready) begin
        seed_word <= seed;
      end

      // step counter and multiply phase
      unique case (state)
        mt64_pkg::ST_IDLE: begin
          if (in_xfer && need_seed) begin
            read_index <= mt64_pkg::IDX_SPENT;
          end
        end
        mt64_pkg::ST_SEED_FIRST: begin
          k     <= AW'(1);
          phase <= mt64_pkg::PH_LO_LO;
        end
        mt64_pkg::ST_SEED_MUL: begin
          phase <= mt64_pkg::seed_phase_t'(phase + 2'd1);
          if (phase == mt64_pkg::PH_SUM) begin
            k <= (k == mt64_pkg::IDX_LAST) ? '0 : (k + AW'(1));
          end
        end
        mt64_pkg::ST_TW_PRE: k <= '0;
        mt64_pkg::ST_TW_WRITE: begin
          if (k == mt64_pkg::IDX_LAST) begin
            read_index <= '0;
          end else begin
            k <= k + AW'(1);
          end
        end
        mt64_pkg::ST_FETCH: read_index <= read_index + AW'(1);
        default: begin
        end
      endcase

      // result register valid
      if (state == mt64_pkg::ST_DRAW && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      mt64_pkg::ST_SEED_FIRST: prev <= seed_word;
      mt64_pkg::ST_SEED_MUL: begin
        prod <= mul_p;
        unique case (phase)
          mt64_pkg::PH_LO_LO: acc  <= acc;
          mt64_pkg::PH_LO_HI: acc  <= prod + {{(WW-AW){1'b0}}, k};
          mt64_pkg::PH_HI_LO: acc  <= seed_sum;
          mt64_pkg::PH_SUM:   prev <= seed_sum;
          default:            acc  <= acc;
        endcase
      end
      mt64_pkg::ST_TW_FAR:  cur      <= ram_rdata;
      mt64_pkg::ST_TW_NEXT: far_word <= ram_rdata;
      mt64_pkg::ST_DRAW: begin
        if (out_free) begin
          random_word   <= tempered;
          unit_fraction <= {tempered[63:12], 1'b1};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

>>> design/mt64_ram.sv
// ----------------------------------------------------------------------------
// mt64_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mt64_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 312
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> tb/mersenne_twister_64_generator_tb.sv
// ----------------------------------------------------------------------------
// mersenne_twister_64_generator_tb
// Self-checking bench for the 64-bit Mersenne Twister generator. Draw
// requests go in with random gaps and restarts, and the result side
// stalls at random. A scoreboard keeps its own copy of the state pool and
// seed register. It predicts each tempered word and its unit fraction and
// compares them with every result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mersenne_twister_64_generator_tb;

  // generator constants, kept apart from the design's copy
  localparam logic [63:0] MT_MATRIX   = 64'hB502_6F5A_A966_19E9;
  localparam logic [63:0] MT_UPPER    = 64'hFFFF_FFFF_8000_0000;
  localparam logic [63:0] MT_LOWER    = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] MT_SEED_MUL = 64'd6364136223846793005;
  localparam logic [63:0] MT_TEMPER_B = 64'h5555_5555_5555_5555;
  localparam logic [63:0] MT_TEMPER_C = 64'h71D6_7FFF_EDA6_0000;
  localparam logic [63:0] MT_TEMPER_D = 64'hFFF7_EEE0_0000_0000;
  localparam logic [63:0] MT_DEFAULT  = 64'd5489;
  localparam int          POOL_DEPTH  = 312;
  localparam int          POOL_MID    = 156;

  // receiver hold-off that backs up the request side
  localparam int HOLD_AFTER  = 120;
  localparam int HOLD_CYCLES = 400;

  // --------------------------------------------------------------------------
  // scoreboard: predicted pool state and the queue of expected words
  // --------------------------------------------------------------------------
  class draw_checker;
    logic [63:0] seed_reg;
    logic [63:0] pool [POOL_DEPTH];
    int unsigned pool_idx;
    logic [63:0] pending_words [$];
    int unsigned error_count;
    int unsigned checked_count;
    int unsigned restart_count;
    int unsigned twist_count;
    int unsigned seed_writes;

    function new();
      seed_reg      = MT_DEFAULT;
      pool_idx      = POOL_DEPTH + 1;
      error_count   = 0;
      checked_count = 0;
      restart_count = 0;
      twist_count   = 0;
      seed_writes   = 0;
      foreach (pool[k]) pool[k] = '0;
    endfunction

    function void set_seed(logic [63:0] value);
      seed_reg = value;
      seed_writes++;
    endfunction

    // accepted draw request: advance the pool and queue the tempered word
    function void note_draw(logic rs);
      logic [63:0] y;
      logic [63:0] w;
      int unsigned k;
      // seed on restart or on the first draw after reset
      if (rs || pool_idx > POOL_DEPTH) begin
        pool[0] = seed_reg;
        for (k = 1; k < POOL_DEPTH; k++)
          pool[k] = MT_SEED_MUL * (pool[k-1] ^ (pool[k-1] >> 62)) + 64'(k);
        pool_idx = POOL_DEPTH;
        if (rs) restart_count++;
      end
      // pool spent: twist all words in place
      if (pool_idx >= POOL_DEPTH) begin
        for (k = 0; k < POOL_DEPTH; k++) begin
          y = (pool[k] & MT_UPPER) | (pool[(k + 1) % POOL_DEPTH] & MT_LOWER);
          pool[k] = pool[(k + POOL_MID) % POOL_DEPTH] ^ (y >> 1)
                    ^ (y[0] ? MT_MATRIX : 64'd0);
        end
        pool_idx = 0;
        twist_count++;
      end
      // temper
      w = pool[pool_idx];
      pool_idx++;
      w ^= (w >> 29) & MT_TEMPER_B;
      w ^= (w << 17) & MT_TEMPER_C;
      w ^= (w << 37) & MT_TEMPER_D;
      w ^= (w >> 43);
      pending_words.push_back(w);
    endfunction

    // result transfer: compare with the oldest expected word
    function void check_result(logic [63:0] word, logic [52:0] frac);
      logic [63:0] exp_word;
      logic [52:0] exp_frac;
      if (pending_words.size() == 0) begin
        $error("unexpected result transfer: random_word %h", word);
        error_count++;
        return;
      end
      exp_word = pending_words.pop_front();
      exp_frac = {exp_word[63:12], 1'b1};
      checked_count++;
      if (word !== exp_word) begin
        $error("random_word: expected %h, actual %h", exp_word, word);
        error_count++;
      end
      if (frac !== exp_frac) begin
        $error("unit_fraction: expected %h, actual %h", exp_frac, frac);
        error_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        restart;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] random_word;
  logic [52:0] unit_fraction;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [63:0] seed;

  draw_checker board = new();

  mersenne_twister_64_generator u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .restart       (restart),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .random_word   (random_word),
    .unit_fraction (unit_fraction),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .seed          (seed)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2_500_000;
    $display("== FAIL ==");
    $finish;
  end

  // result check on every output transfer
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_result(random_word, unit_fraction);
  end

  // result side stall: quiet stretches, short and long stalls, one long hold-off
  initial begin : result_sink
    int unsigned pick;
    bit held_off;
    held_off = 1'b0;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && board.checked_count >= HOLD_AFTER) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end else if (pick < 90) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end
    end
  end

  // one draw request after a random gap; valid stays high across back-to-back items
  task automatic draw_item(input logic rs);
    int unsigned pick;
    int unsigned gap;
    pick = $urandom_range(0, 99);
    gap  = (pick < 55) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(10, 50);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (!in_valid) in_valid <= 1'b1;
    restart <= rs;
    do @(posedge clk); while (in_stall);
    board.note_draw(rs);
  endtask

  // drop valid and wait until every expected word is back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // seed register transfer
  task automatic write_seed(input logic [63:0] value);
    cfg_valid <= 1'b1;
    seed      <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_seed(value);
  endtask

  // new seed, restart, then random draws that each restart with a chance of pct percent
  task automatic run_random_phase(input logic [63:0] value, input int unsigned pct,
                                  input int unsigned count);
    wait_idle();
    write_seed(value);
    draw_item(1'b1);
    repeat (count - 1) draw_item($urandom_range(0, 99) < pct);
  endtask

  initial begin : stimulus
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    restart   <= 1'b0;
    cfg_valid <= 1'b0;
    seed      <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default seed: first draw seeds an unseeded pool, then a restart
    draw_item(1'b0);
    repeat (3) draw_item(1'b0);
    draw_item(1'b1);
    repeat (2) draw_item(1'b0);

    // zero seed: takes effect only at the restart
    wait_idle();
    write_seed('0);
    draw_item(1'b0);
    draw_item(1'b1);
    repeat (2) draw_item(1'b0);

    // all-ones seed, back-to-back restarts
    wait_idle();
    write_seed('1);
    draw_item(1'b1);
    repeat (2) draw_item(1'b0);
    draw_item(1'b1);
    draw_item(1'b1);

    // random phases: a long run past the twist, then rarer and frequent restarts
    run_random_phase({$urandom, $urandom}, 0, 340);
    run_random_phase({$urandom, $urandom}, 4, 150);
    run_random_phase({$urandom, $urandom}, 15, 140);

    wait_idle();
    repeat (20) @(posedge clk);
    $display("checked %0d words over %0d seed settings", board.checked_count,
             board.seed_writes + 1);
    $display("%0d restarts, %0d pool twists", board.restart_count, board.twist_count);
    if (board.error_count == 0 && board.pending_words.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
